// ===== hdl/dqbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqbs_pkg: shared types for the deque with bag search
// operation and status codes, datapath micro-commands and status
// ----------------------------------------------------------------------------
package dqbs_pkg;

    localparam int OP_W        = 3;
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_PAD_W   = 7;
    localparam int OUT_DATA_W  = 2 * FIELD_W + COUNT_OUT_W + 4 + OUT_PAD_W;

    // request operation codes; codes six and seven do nothing
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_REMOVE     = 3'd5
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH_FRONT,
        DP_PUSH_BACK,
        DP_POP_FRONT,
        DP_POP_BACK,
        DP_FLAG_FULL,
        DP_FLAG_EMPTY,
        DP_SCAN_START,
        DP_SCAN_NEXT,
        DP_MATCH,
        DP_SHIFT_START,
        DP_SHIFT_STEP,
        DP_SHRINK,
        DP_READ_FRONT,
        DP_READ_BACK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            match;
        logic            last_pos;
        logic            shift_more;
    } dp_stat_t;

endpackage

// ===== hdl/dqbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqbs_ctrl: sequencer for the deque with bag search
// walks each request through execute, scan, shift and read-out steps
// ----------------------------------------------------------------------------
module dqbs_ctrl
    import dqbs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_READ_F,
        S_READ_B,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = in_ready_reg;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = DP_NOP;
        cmd.out_load   = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && in_ready_reg) begin
                    cmd.op        = DP_LOAD;
                    in_ready_next = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_READ_F;
                case (deq_op_t'(stat.op))
                    OP_PUSH_FRONT: cmd.op = stat.full ? DP_FLAG_FULL : DP_PUSH_FRONT;
                    OP_PUSH_BACK:  cmd.op = stat.full ? DP_FLAG_FULL : DP_PUSH_BACK;
                    OP_POP_FRONT:  cmd.op = stat.empty ? DP_FLAG_EMPTY : DP_POP_FRONT;
                    OP_POP_BACK:   cmd.op = stat.empty ? DP_FLAG_EMPTY : DP_POP_BACK;
                    OP_CONTAINS, OP_REMOVE: begin
                        if (!stat.empty) begin
                            cmd.op     = DP_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    default: cmd.op = DP_NOP;
                endcase
            end
            S_SCAN: begin
                if (stat.match) begin
                    if (deq_op_t'(stat.op) == OP_CONTAINS) begin
                        cmd.op     = DP_MATCH;
                        state_next = S_READ_F;
                    end else if (stat.last_pos) begin
                        cmd.op     = DP_SHRINK;
                        state_next = S_READ_F;
                    end else begin
                        cmd.op     = DP_SHIFT_START;
                        state_next = S_SHIFT;
                    end
                end else if (stat.last_pos) begin
                    state_next = S_READ_F;
                end else begin
                    cmd.op = DP_SCAN_NEXT;
                end
            end
            S_SHIFT: begin
                cmd.op = DP_SHIFT_STEP;
                if (!stat.shift_more) begin
                    state_next = S_READ_F;
                end
            end
            S_READ_F: begin
                cmd.op     = DP_READ_FRONT;
                state_next = S_READ_B;
            end
            S_READ_B: begin
                cmd.op     = DP_READ_BACK;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready_reg |-> (state_reg == S_IDLE))
        else $error("ready raised outside idle");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && in_ready_reg) |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while held");

endmodule

// ===== hdl/dqbs_datapath.sv =====
// ----------------------------------------------------------------------------
// dqbs_datapath: storage and pointers for the deque with bag search
// circular entry memory, head and count, scan position, result register
// ----------------------------------------------------------------------------
module dqbs_datapath
    import dqbs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [OP_W-1:0]       in_op,
    input  logic [FIELD_W-1:0]    in_value,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [SW-1:0]         mem [DEPTH];
    logic [SW-1:0]         rd_data_reg;
    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         pos_reg;
    logic [OP_W-1:0]       op_reg;
    logic [SW-1:0]         val_reg;
    logic                  found_reg;
    status_t               status_reg;
    logic [FIELD_W-1:0]    front_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [AW-1:0] head_dec, head_inc;
    logic [CW-1:0] pos_p1, pos_p2, count_m1;
    logic          wr_en, rd_en;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] wdata;
    logic          is_empty;
    logic [FIELD_W-1:0] rd_field;

    // head plus offset, wrapped once into the store
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign pos_p1   = pos_reg + 1'b1;
    assign pos_p2   = pos_reg + 2'd2;
    assign count_m1 = count_reg - 1'b1;
    assign is_empty = (count_reg == '0);
    assign rd_field = FIELD_W'(rd_data_reg);

    assign stat.op         = op_reg;
    assign stat.full       = (count_reg == DEPTH_C);
    assign stat.empty      = is_empty;
    assign stat.match      = (rd_data_reg == val_reg);
    assign stat.last_pos   = (pos_p1 == count_reg);
    assign stat.shift_more = (pos_p2 < count_reg);

    always_comb begin
        wr_en = 1'b0;
        waddr = slot_of(head_reg, AW'(count_reg));
        wdata = val_reg;
        rd_en = 1'b0;
        raddr = slot_of(head_reg, '0);
        case (cmd.op)
            DP_PUSH_FRONT: begin
                wr_en = 1'b1;
                waddr = head_dec;
            end
            DP_PUSH_BACK: begin
                wr_en = 1'b1;
            end
            DP_SCAN_START, DP_READ_FRONT: begin
                rd_en = 1'b1;
            end
            DP_SCAN_NEXT, DP_SHIFT_START: begin
                rd_en = 1'b1;
                raddr = slot_of(head_reg, AW'(pos_p1));
            end
            DP_SHIFT_STEP: begin
                // move the entry behind the gap forward by one
                wr_en = 1'b1;
                waddr = slot_of(head_reg, AW'(pos_reg));
                wdata = rd_data_reg;
                rd_en = stat.shift_more;
                raddr = slot_of(head_reg, AW'(pos_p2));
            end
            DP_READ_BACK: begin
                rd_en = !is_empty;
                raddr = slot_of(head_reg, AW'(count_m1));
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            case (cmd.op)
                DP_PUSH_FRONT: begin
                    head_reg  <= head_dec;
                    count_reg <= count_reg + 1'b1;
                end
                DP_PUSH_BACK:  count_reg <= count_reg + 1'b1;
                DP_POP_FRONT: begin
                    head_reg  <= head_inc;
                    count_reg <= count_m1;
                end
                DP_POP_BACK:   count_reg <= count_m1;
                DP_SHRINK:     count_reg <= count_m1;
                DP_SHIFT_STEP: begin
                    if (!stat.shift_more) begin
                        count_reg <= count_m1;
                    end
                end
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                op_reg     <= in_op;
                val_reg    <= SW'(in_value);
                found_reg  <= 1'b0;
                status_reg <= ST_OK;
            end
            DP_FLAG_FULL:   status_reg <= ST_FULL;
            DP_FLAG_EMPTY:  status_reg <= ST_EMPTY;
            DP_SCAN_START:  pos_reg <= '0;
            DP_SCAN_NEXT:   pos_reg <= pos_p1;
            DP_MATCH:       found_reg <= 1'b1;
            DP_SHIFT_START: found_reg <= 1'b1;
            DP_SHRINK:      found_reg <= 1'b1;
            DP_SHIFT_STEP:  pos_reg <= pos_p1;
            DP_READ_BACK:   front_reg <= is_empty ? '0 : rd_field;
            default:        pos_reg <= pos_reg;
        endcase
        if (cmd.out_load) begin
            out_reg <= {{OUT_PAD_W{1'b0}}, status_reg, found_reg, is_empty,
                        COUNT_OUT_W'(count_reg),
                        (is_empty ? {FIELD_W{1'b0}} : rd_field), front_reg};
        end
    end

    assign out_data = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, head_reg} < DEPTH_W)
        else $error("head index outside store");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_SCAN_NEXT || cmd.op == DP_SHIFT_START) |-> (pos_p1 < count_reg))
        else $error("scan position beyond stored entries");

endmodule

// ===== hdl/deque_with_bag_search.sv =====
// ----------------------------------------------------------------------------
// deque_with_bag_search: bounded double-ended queue with bag search
// push/pop at either end, membership test and remove-first-match
// ----------------------------------------------------------------------------
// sequence: push, pop, contains on empty and no-op codes are executed, then
//   the front and back entries are read and the result loaded; contains
//   also scans the entries one at a time and remove scans and then shifts
//   them, the scanned plus shifted entries never exceeding the stored count,
//   as the single memory read port serves one entry per step
// throughput: one request at a time; the next one can be taken while the
//   previous result still waits in the output register
// reset: synchronous active low; empties the queue, the entry memory is not
//   cleared since unused entries never reach the result
module deque_with_bag_search
    import dqbs_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FIELD_W-1:0]    s_tdata,   // [31:0] item_value
    input  logic [OP_W-1:0]       s_tuser,   // [2:0] op
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] front_value, [63:32] back_value, [68:64] entry_count,
    // [69] is_empty, [70] found, [72:71] status, [79:73] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accepts a request, steps through execute, scan and shift,
    // then reads front and back entries and loads the result register
    dqbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath: circular entry memory with one write and one registered
    // read port, head and count pointers, scan position and result register
    dqbs_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_op    (s_tuser),
        .in_value (s_tdata),
        .out_data (m_tdata)
    );

endmodule
